FILE: src/fqks_pkg.sv
// Shared types and codes for the FIFO queue with key search.
package fqks_pkg;

  localparam int KEY_W = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_UPDATE = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] new_key;
  } fqks_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] position;
  } fqks_out_t;

endpackage

FILE: src/fifo_queue_with_key_search.sv
// FIFO ring of name keys with insert, remove, search and update.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   in_     | input     | in_valid / in_ready   | in_data  (opcode, key, new_key)
//   out_    | output    | out_valid / out_ready | out_data (status, position)
//
// Insert and remove go from acceptance straight to S_DONE, which registers out_valid.
// Search and update read one stored key per cycle through the single memory
// read port, scanning from the head until a match or until every stored key
// has been compared.
// One transaction at a time: in_ready is high only while the sequencer is idle.
// A result stalled by out_ready holds the sequencer in its final state.
// rst_n is synchronous; it empties the queue, stored keys are not cleared.
module fifo_queue_with_key_search #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NAME_BITS   = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fqks_pkg::fqks_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fqks_pkg::fqks_out_t out_data
);
  import fqks_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int PW = (CW > 5) ? CW : 5;
  localparam logic [IW-1:0] IDX_LAST = IW'(QUEUE_DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [NAME_BITS-1:0] mem [QUEUE_DEPTH];
  logic [NAME_BITS-1:0] mem_q;

  logic [1:0]           state_r, state_nxt;
  logic [IW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [IW-1:0]        cmp_ptr_r, cmp_ptr_nxt;
  logic [IW-1:0]        iss_ptr_r, iss_ptr_nxt;
  logic [CW-1:0]        cmp_off_r, cmp_off_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [NAME_BITS-1:0] key_r, key_nxt;
  logic [NAME_BITS-1:0] nkey_r, nkey_nxt;
  logic [1:0]           res_st_r, res_st_nxt;
  logic [4:0]           res_pos_r, res_pos_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fqks_out_t            out_data_r, out_data_nxt;

  logic                 in_fire;
  logic [IW-1:0]        rd_addr;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [NAME_BITS-1:0] mem_wdata;
  logic [SW-1:0]        tail_sum;
  logic [IW-1:0]        tail_idx;
  logic [PW-1:0]        pos_w;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    wrap_inc = (p == IDX_LAST) ? '0 : p + 1'b1;
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Tail slot: head + count stays below twice the depth.
  assign tail_sum = SW'(head_r) + SW'(cnt_r);
  assign tail_idx = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : IW'(tail_sum);
  assign pos_w    = PW'(cmp_off_r) + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    cmp_ptr_nxt   = cmp_ptr_r;
    iss_ptr_nxt   = iss_ptr_r;
    cmp_off_nxt   = cmp_off_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    nkey_nxt      = nkey_r;
    res_st_nxt    = res_st_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_addr       = iss_ptr_r;
    mem_we        = 1'b0;
    mem_waddr     = tail_idx;
    mem_wdata     = in_data.key[NAME_BITS-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        rd_addr = head_r;
        if (in_fire) begin
          op_nxt      = in_data.opcode;
          key_nxt     = in_data.key[NAME_BITS-1:0];
          nkey_nxt    = in_data.new_key[NAME_BITS-1:0];
          res_st_nxt  = ST_OK;
          res_pos_nxt = '0;
          cmp_ptr_nxt = head_r;
          iss_ptr_nxt = wrap_inc(head_r);
          cmp_off_nxt = '0;
          state_nxt   = S_DONE;
          case (in_data.opcode)
            OP_INSERT: begin
              if (cnt_r == DEPTH_C) begin
                res_st_nxt = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_UNDERFLOW;
              end else begin
                head_nxt = wrap_inc(head_r);
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                res_st_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // mem_q holds the key at cmp_ptr_r; iss_ptr_r is fetched meanwhile.
        iss_ptr_nxt = wrap_inc(iss_ptr_r);
        cmp_ptr_nxt = wrap_inc(cmp_ptr_r);
        cmp_off_nxt = cmp_off_r + 1'b1;
        if (mem_q == key_r) begin
          res_pos_nxt = pos_w[4:0];
          state_nxt   = S_DONE;
          if (op_r == OP_UPDATE) begin
            mem_we    = 1'b1;
            mem_waddr = cmp_ptr_r;
            mem_wdata = nkey_r;
          end
        end else if (cmp_off_r + 1'b1 == cnt_r) begin
          res_st_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = res_st_r;
          out_data_nxt.position = res_pos_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_ptr_r  <= cmp_ptr_nxt;
    iss_ptr_r  <= iss_ptr_nxt;
    cmp_off_r  <= cmp_off_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    nkey_r     <= nkey_nxt;
    res_st_r   <= res_st_nxt;
    res_pos_r  <= res_pos_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count exceeds queue depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cmp_off_r < cnt_r)
    else $error("scan offset past the last stored entry");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.opcode == OP_INSERT && cnt_r != DEPTH_C
    |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("insert did not grow the queue");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.opcode == OP_REMOVE && cnt_r != '0
    |=> cnt_r == $past(cnt_r) - 1'b1 && head_r == wrap_inc($past(head_r)))
    else $error("remove did not advance the head");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_ready |=> state_r == S_DONE)
    else $error("result left its final state while output stalled");
`endif

endmodule
